FILE: src/assert_macros.svh
// Assertion helpers included by the top-level unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define DPWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true.
`define DPWM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `DPWM_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: src/dpwm_pkg.sv
// ----------------------------------------------------------------------------
// dpwm_pkg
// Shared types and constants of the debounce and pulse width monitor.
// ----------------------------------------------------------------------------
package dpwm_pkg;

    localparam int NUM_PINS_DEF = 32;
    localparam int PIN_W        = 5;
    localparam int TIME_W       = 32;
    localparam int CNT_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK    = 2'd2;

    localparam logic [CNT_W-1:0]  LIMIT_RST   = 8'd3;
    localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd86400000;

    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_FALL = 2'd2;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_NULL   = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [PIN_W-1:0]  pin;
        logic              raw;
        logic [TIME_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_stat_t;

    typedef struct packed {
        logic [CNT_W-1:0]  limit;
        logic [TIME_W-1:0] timeout;
        logic [31:0]       invert;
    } cfg_t;

endpackage

FILE: src/dpwm_front.sv
// ----------------------------------------------------------------------------
// dpwm_front
// Accepts input words, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module dpwm_front #(
    parameter int NUM_PINS = dpwm_pkg::NUM_PINS_DEF
) (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [dpwm_pkg::PIN_W-1:0]    s_pin_index,
    input  logic                          s_raw_level,
    input  logic [dpwm_pkg::TIME_W-1:0]   s_now_ms,
    input  dpwm_pkg::queue_stat_t         q_stat,
    output dpwm_pkg::push_t               push
);

    logic pin_ok;

    assign pin_ok  = (32'(s_pin_index) < NUM_PINS);
    assign s_ready = !q_stat.full;

    always_comb begin
        push.valid    = s_valid && !q_stat.full;
        push.item.pin = s_pin_index;
        push.item.raw = s_raw_level;
        push.item.now = s_now_ms;
        // pins beyond the monitored range report all zeros
        if (!pin_ok) begin
            push.item.op = dpwm_pkg::OP_NULL;
        end else if (s_func) begin
            push.item.op = dpwm_pkg::OP_CLEAR;
        end else begin
            push.item.op = dpwm_pkg::OP_SAMPLE;
        end
    end

endmodule

FILE: src/dpwm_queue.sv
// ----------------------------------------------------------------------------
// dpwm_queue
// Short FIFO between the front and the back stage.
// ----------------------------------------------------------------------------
module dpwm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dpwm_pkg::push_t       push,
    input  logic                  pop,
    output dpwm_pkg::item_t       q_item,
    output dpwm_pkg::queue_stat_t q_stat
);

    localparam int PTR_W = (dpwm_pkg::QUEUE_DEPTH > 1) ? $clog2(dpwm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(dpwm_pkg::QUEUE_DEPTH + 1);

    dpwm_pkg::item_t    mem_reg [dpwm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == CNT_QW'(dpwm_pkg::QUEUE_DEPTH));
    assign q_item       = mem_reg[rd_ptr_reg];
    assign do_push      = push.valid && !q_stat.full;
    assign do_pop       = pop && q_stat.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == dpwm_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == dpwm_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_QW'(do_push) - CNT_QW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

FILE: src/dpwm_back.sv
// ----------------------------------------------------------------------------
// dpwm_back
// Per-pin debounce state, edge and width update, registered result word.
// ----------------------------------------------------------------------------
module dpwm_back #(
    parameter int NUM_PINS = dpwm_pkg::NUM_PINS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dpwm_pkg::cfg_t                cfg,
    input  dpwm_pkg::item_t               q_item,
    input  logic                          q_valid,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_pin_level,
    output logic [1:0]                    m_edge_res,
    output logic [dpwm_pkg::TIME_W-1:0]   m_low_width_ms,
    output logic [dpwm_pkg::TIME_W-1:0]   m_high_width_ms
);

    localparam int PIN_SPAN = 1 << dpwm_pkg::PIN_W;
    localparam int DEPTH    = (NUM_PINS < PIN_SPAN) ? NUM_PINS : PIN_SPAN;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [dpwm_pkg::CNT_W-1:0]  cnt_reg   [DEPTH];
    logic                        lvl_reg   [DEPTH];
    logic [dpwm_pkg::TIME_W-1:0] ct_reg    [DEPTH];
    logic [dpwm_pkg::TIME_W-1:0] lw_reg    [DEPTH];
    logic [dpwm_pkg::TIME_W-1:0] hw_reg    [DEPTH];

    logic                        m_valid_reg;
    logic                        level_reg;
    logic [1:0]                  edge_reg;
    logic [dpwm_pkg::TIME_W-1:0] low_reg;
    logic [dpwm_pkg::TIME_W-1:0] high_reg;

    logic [IDX_W-1:0]            idx;
    logic [dpwm_pkg::CNT_W-1:0]  cnt_cur, cnt_next;
    logic                        lvl_cur, lvl_next;
    logic [dpwm_pkg::TIME_W-1:0] ct_cur, ct_next;
    logic [dpwm_pkg::TIME_W-1:0] lw_next, hw_next;
    logic [dpwm_pkg::TIME_W-1:0] diff;
    logic                        stale;
    logic [1:0]                  edge_next;
    logic                        level_out;

    assign pop         = q_valid && (!m_valid_reg || m_ready);
    assign idx         = q_item.pin[IDX_W-1:0];
    assign cnt_cur     = cnt_reg[idx];
    assign lvl_cur     = lvl_reg[idx];
    assign ct_cur      = ct_reg[idx];
    assign diff        = q_item.now - ct_cur;

    always_comb begin
        cnt_next  = cnt_cur;
        lvl_next  = lvl_cur;
        ct_next   = ct_cur;
        lw_next   = lw_reg[idx];
        hw_next   = hw_reg[idx];
        edge_next = dpwm_pkg::EDGE_NONE;
        stale     = 1'b0;
        unique case (q_item.op)
            dpwm_pkg::OP_SAMPLE: begin
                if (q_item.raw) begin
                    if (cnt_cur < cfg.limit) begin
                        cnt_next = cnt_cur + 1'b1;
                    end else if (!lvl_cur) begin
                        lw_next   = diff;
                        ct_next   = q_item.now;
                        lvl_next  = 1'b1;
                        edge_next = dpwm_pkg::EDGE_RISE;
                    end
                end else begin
                    if (cnt_cur != '0) begin
                        cnt_next = cnt_cur - 1'b1;
                    end else if (lvl_cur) begin
                        hw_next   = diff;
                        ct_next   = q_item.now;
                        lvl_next  = 1'b0;
                        edge_next = dpwm_pkg::EDGE_FALL;
                    end
                end
                // after an edge the elapsed time is zero
                stale = (edge_next != dpwm_pkg::EDGE_NONE) ? (cfg.timeout == '0)
                                                           : (diff >= cfg.timeout);
                if (stale) begin
                    lw_next = '0;
                    hw_next = '0;
                end
            end
            dpwm_pkg::OP_CLEAR: begin
                lw_next = '0;
                hw_next = '0;
            end
            default: begin
                lw_next = '0;
                hw_next = '0;
            end
        endcase
        level_out = (q_item.op == dpwm_pkg::OP_NULL) ? 1'b0
                                                    : (lvl_next ^ cfg.invert[q_item.pin]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                cnt_reg[i] <= '0;
                lvl_reg[i] <= 1'b0;
                ct_reg[i]  <= '0;
                lw_reg[i]  <= '0;
                hw_reg[i]  <= '0;
            end
        end else if (pop && (q_item.op != dpwm_pkg::OP_NULL)) begin
            cnt_reg[idx] <= cnt_next;
            lvl_reg[idx] <= lvl_next;
            ct_reg[idx]  <= ct_next;
            lw_reg[idx]  <= lw_next;
            hw_reg[idx]  <= hw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // hold the result word until it is taken
    always_ff @(posedge aclk) begin
        if (pop) begin
            level_reg <= level_out;
            edge_reg  <= edge_next;
            low_reg   <= lw_next;
            high_reg  <= hw_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pin_level     = level_reg;
    assign m_edge_res      = edge_reg;
    assign m_low_width_ms  = low_reg;
    assign m_high_width_ms = high_reg;

endmodule

FILE: src/debounce_pulse_width_monitor_unit.sv
// ----------------------------------------------------------------------------
// debounce_pulse_width_monitor_unit
// Integrating per-pin debouncer with low and high pulse width capture.
// ----------------------------------------------------------------------------
// Sustains one word per cycle in both directions while m_ready is held high:
// each accepted word is stored in the queue, then in the result register, and
// the rate is set by the back stage's read-modify-write of the pin's state.
// A two-word queue separates the input side from the back stage, so input is
// still taken while a result waits on m_ready. Reset clears all per-pin state
// at once; configuration writes take effect on the next cycle.
module debounce_pulse_width_monitor_unit #(
    parameter int NUM_PINS = dpwm_pkg::NUM_PINS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [dpwm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [dpwm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [dpwm_pkg::PIN_W-1:0]        s_pin_index,
    input  logic                              s_raw_level,
    input  logic [dpwm_pkg::TIME_W-1:0]       s_now_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_pin_level,
    output logic [1:0]                        m_edge_res,
    output logic [dpwm_pkg::TIME_W-1:0]       m_low_width_ms,
    output logic [dpwm_pkg::TIME_W-1:0]       m_high_width_ms
);

`include "assert_macros.svh"

    dpwm_pkg::cfg_t        cfg_reg;
    dpwm_pkg::push_t       push;
    dpwm_pkg::item_t       q_item;
    dpwm_pkg::queue_stat_t q_stat;
    logic                  pop;
    logic [2:0]            inflight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.limit   <= dpwm_pkg::LIMIT_RST;
            cfg_reg.timeout <= dpwm_pkg::TIMEOUT_RST;
            cfg_reg.invert  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                dpwm_pkg::REG_DEBOUNCE_LIMIT: cfg_reg.limit   <= cfg_wdata[dpwm_pkg::CNT_W-1:0];
                dpwm_pkg::REG_STALE_TIMEOUT:  cfg_reg.timeout <= cfg_wdata;
                dpwm_pkg::REG_INVERT_MASK:    cfg_reg.invert  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    dpwm_front #(
        .NUM_PINS (NUM_PINS)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_pin_index (s_pin_index),
        .s_raw_level (s_raw_level),
        .s_now_ms    (s_now_ms),
        .q_stat      (q_stat),
        .push        (push)
    );

    dpwm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .q_item  (q_item),
        .q_stat  (q_stat)
    );

    dpwm_back #(
        .NUM_PINS (NUM_PINS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_item          (q_item),
        .q_valid         (q_stat.valid),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pin_level     (m_pin_level),
        .m_edge_res      (m_edge_res),
        .m_low_width_ms  (m_low_width_ms),
        .m_high_width_ms (m_high_width_ms)
    );

    // words accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + 3'(s_valid && s_ready) - 3'(m_valid && m_ready);
        end
    end

    `DPWM_ASSERT_NEVER(a_edge_code, aclk, aresetn, m_valid && (m_edge_res == 2'd3), "bad edge code")
    `DPWM_ASSERT(a_stall_full, aclk, aresetn, !s_ready |-> (inflight_reg >= 3'(dpwm_pkg::QUEUE_DEPTH)), "input stalled with queue space")
    `DPWM_ASSERT(a_result_source, aclk, aresetn, $rose(m_valid) |-> $past(q_stat.valid), "result without queued word")
    `DPWM_ASSERT_NEVER(a_phantom, aclk, aresetn, m_valid && (inflight_reg == '0), "result with nothing in flight")

endmodule

FILE: tb/tb_debounce_pulse_width_monitor_unit.sv
// ----------------------------------------------------------------------------
// tb_debounce_pulse_width_monitor_unit
// Self-checking bench for the per-pin debouncer with pulse width capture.
// Sample and clear words are queued, driven in random bursts and checked
// against an in-bench model of every pin's counter, level, change time and
// widths. Results drain under several receiver stall patterns, and the
// registers change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_debounce_pulse_width_monitor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dpwm_pkg::*;

    localparam int  PIN_COUNT  = NUM_PINS_DEF;
    localparam int  IDLE_LIMIT = 2000;
    localparam int  PRINT_CAP  = 200;
    localparam bit  FUNC_SAMPLE = 1'b0;
    localparam bit  FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [PIN_W-1:0]  pin;
        logic              raw;
        logic [TIME_W-1:0] now;
    } sample_word_t;

    typedef struct packed {
        logic              level;
        logic [1:0]        edge_kind;
        logic [TIME_W-1:0] low_w;
        logic [TIME_W-1:0] high_w;
    } pin_report_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_func    = 1'b0;
    logic [PIN_W-1:0]      s_pin_index = '0;
    logic                  s_raw_level = 1'b0;
    logic [TIME_W-1:0]     s_now_ms  = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_pin_level;
    logic [1:0]            m_edge_res;
    logic [TIME_W-1:0]     m_low_width_ms;
    logic [TIME_W-1:0]     m_high_width_ms;

    debounce_pulse_width_monitor_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_pin_index     (s_pin_index),
        .s_raw_level     (s_raw_level),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pin_level     (m_pin_level),
        .m_edge_res      (m_edge_res),
        .m_low_width_ms  (m_low_width_ms),
        .m_high_width_ms (m_high_width_ms)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Register copies and per-pin state of the model
    logic [CNT_W-1:0]  limit_cfg   = LIMIT_RST;
    logic [TIME_W-1:0] timeout_cfg = TIMEOUT_RST;
    logic [31:0]       invert_cfg  = '0;

    logic [CNT_W-1:0]  count_st  [PIN_COUNT] = '{default: '0};
    logic              level_st  [PIN_COUNT] = '{default: 1'b0};
    logic [TIME_W-1:0] change_st [PIN_COUNT] = '{default: '0};
    logic [TIME_W-1:0] low_st    [PIN_COUNT] = '{default: '0};
    logic [TIME_W-1:0] high_st   [PIN_COUNT] = '{default: '0};

    sample_word_t pending_words[$];
    pin_report_t  expected_reports[$];

    int mismatch_count = 0;
    int result_count   = 0;
    int idle_cycles    = 0;
    logic in_taken     = 1'b0;

    logic [TIME_W-1:0] clock_ms;

    function automatic pin_report_t predict_pin(logic func, logic [PIN_W-1:0] pin,
                                                logic raw, logic [TIME_W-1:0] now);
        pin_report_t       r;
        int                p;
        logic [TIME_W-1:0] age;
        r = '0;
        r.edge_kind = EDGE_NONE;
        p = int'(pin);
        if (p >= PIN_COUNT) begin
            return r;
        end
        if (func == FUNC_CLEAR) begin
            low_st[p]  = '0;
            high_st[p] = '0;
        end else begin
            if (raw) begin
                if (count_st[p] < limit_cfg) begin
                    count_st[p] = count_st[p] + 8'd1;
                end else if (!level_st[p]) begin
                    low_st[p]    = now - change_st[p];
                    change_st[p] = now;
                    level_st[p]  = 1'b1;
                    r.edge_kind  = EDGE_RISE;
                end
            end else begin
                if (count_st[p] > 0) begin
                    count_st[p] = count_st[p] - 8'd1;
                end else if (level_st[p]) begin
                    high_st[p]   = now - change_st[p];
                    change_st[p] = now;
                    level_st[p]  = 1'b0;
                    r.edge_kind  = EDGE_FALL;
                end
            end
            // stale widths clear after edge handling
            age = now - change_st[p];
            if (age >= timeout_cfg) begin
                low_st[p]  = '0;
                high_st[p] = '0;
            end
        end
        r.level  = level_st[p] ^ ((p < 32) ? invert_cfg[p] : 1'b0);
        r.low_w  = low_st[p];
        r.high_w = high_st[p];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("mismatch at result %0d: %s", result_count, what);
        end
    endtask

    task automatic check_report(pin_report_t want);
        if (m_pin_level !== want.level) begin
            report_mismatch($sformatf("pin_level %0b, want %0b", m_pin_level, want.level));
        end
        if (m_edge_res !== want.edge_kind) begin
            report_mismatch($sformatf("edge_res %0d, want %0d", m_edge_res, want.edge_kind));
        end
        if (m_low_width_ms !== want.low_w) begin
            report_mismatch($sformatf("low_width_ms %0h, want %0h",
                                      m_low_width_ms, want.low_w));
        end
        if (m_high_width_ms !== want.high_w) begin
            report_mismatch($sformatf("high_width_ms %0h, want %0h",
                                      m_high_width_ms, want.high_w));
        end
    endtask

    // Input acceptance, prediction and result checking
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_reports.push_back(predict_pin(s_func, s_pin_index, s_raw_level,
                                                   s_now_ms));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                check_report(expected_reports.pop_front());
            end
            result_count++;
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sender: bursts of words separated by random gaps
    int           burst_left = 1;
    int           gap_left   = 0;
    logic         next_valid;
    sample_word_t next_word;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold the word until it is taken
        end else begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() > 0) begin
                next_word  = pending_words.pop_front();
                next_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            s_valid <= next_valid;
            if (next_valid) begin
                s_func      <= next_word.func;
                s_pin_index <= next_word.pin;
                s_raw_level <= next_word.raw;
                s_now_ms    <= next_word.now;
            end
        end
    end

    // Receiver: stall pattern that changes every so often
    int rx_cycle = 0;
    int rx_mode  = 0;

    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 97 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= (rx_cycle[2:0] == 3'd0);
            end
            default: begin
                m_ready <= rx_cycle[4];
            end
        endcase
    end

    task automatic push_word(logic func, logic [PIN_W-1:0] pin, logic raw,
                             logic [TIME_W-1:0] now);
        sample_word_t w;
        w.func = func;
        w.pin  = pin;
        w.raw  = raw;
        w.now  = now;
        pending_words.push_back(w);
    endtask

    // Wait until every queued word is taken and every result has arrived
    task automatic settle();
        while (pending_words.size() != 0 || s_valid || expected_reports.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_DEBOUNCE_LIMIT: begin
                limit_cfg = val[CNT_W-1:0];
            end
            REG_STALE_TIMEOUT: begin
                timeout_cfg = val;
            end
            REG_INVERT_MASK: begin
                invert_cfg = val;
            end
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(logic [CNT_W-1:0] lim, logic [TIME_W-1:0] tmo,
                              logic [31:0] inv);
        settle();
        write_reg(REG_DEBOUNCE_LIMIT, CFG_DATA_W'(lim));
        write_reg(REG_STALE_TIMEOUT, tmo);
        write_reg(REG_INVERT_MASK, inv);
    endtask

    // Mostly clean runs on one pin, mixed with jumps, clears, bounce and noise
    task automatic fill_random(int n);
        int               added;
        int               kind;
        int               run_len;
        int               k;
        logic [PIN_W-1:0] pin;
        logic             lvl;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(0, 9);
            pin  = PIN_W'($urandom_range(0, PIN_COUNT - 1));
            lvl  = 1'($urandom_range(0, 1));
            if (kind <= 5) begin
                run_len = (limit_cfg <= 8) ? limit_cfg + 1 + $urandom_range(0, 3)
                                           : $urandom_range(1, 6);
                for (k = 0; k < run_len; k++) begin
                    clock_ms += $urandom_range(0, 20);
                    push_word(FUNC_SAMPLE, pin, lvl, clock_ms);
                end
                added += run_len;
            end else if (kind == 6) begin
                // jump around the stale timeout
                case ($urandom_range(0, 3))
                    0: clock_ms += timeout_cfg - 1;
                    1: clock_ms += timeout_cfg;
                    2: clock_ms += timeout_cfg + 1;
                    default: clock_ms += $urandom();
                endcase
                push_word(FUNC_SAMPLE, pin, lvl, clock_ms);
                added++;
            end else if (kind == 7) begin
                push_word(FUNC_CLEAR, pin, lvl, $urandom());
                added++;
            end else if (kind == 8) begin
                run_len = $urandom_range(2, 5);
                for (k = 0; k < run_len; k++) begin
                    clock_ms += $urandom_range(0, 3);
                    push_word(FUNC_SAMPLE, pin, lvl ^ k[0], clock_ms);
                end
                added += run_len;
            end else begin
                push_word(FUNC_SAMPLE, pin, lvl, $urandom());
                added++;
            end
        end
    endtask

    int               k_main;
    int               long_pin;
    logic [TIME_W-1:0] t_base;

    initial begin
        clock_ms = $urandom();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Clean rise and fall on pin 0, then the stale boundary
        push_word(FUNC_SAMPLE, 5'd0, 1'b1, 32'd100);
        push_word(FUNC_SAMPLE, 5'd0, 1'b1, 32'd110);
        push_word(FUNC_SAMPLE, 5'd0, 1'b1, 32'd120);
        push_word(FUNC_SAMPLE, 5'd0, 1'b1, 32'd130);
        push_word(FUNC_SAMPLE, 5'd0, 1'b0, 32'd200);
        push_word(FUNC_SAMPLE, 5'd0, 1'b0, 32'd210);
        push_word(FUNC_SAMPLE, 5'd0, 1'b0, 32'd220);
        push_word(FUNC_SAMPLE, 5'd0, 1'b0, 32'd230);
        push_word(FUNC_SAMPLE, 5'd0, 1'b1, 32'd230 + TIMEOUT_RST - 1);
        push_word(FUNC_SAMPLE, 5'd0, 1'b1, 32'd230 + TIMEOUT_RST);
        // Highest pin, edges across the time wrap, then a clear
        t_base = 32'hFFFF_FFF0;
        for (k_main = 0; k_main < 4; k_main++) begin
            push_word(FUNC_SAMPLE, 5'd31, 1'b1, t_base + 32'(k_main));
        end
        for (k_main = 5; k_main < 9; k_main++) begin
            push_word(FUNC_SAMPLE, 5'd31, 1'b0, 32'(k_main));
        end
        push_word(FUNC_CLEAR, 5'd31, 1'b1, 32'hFFFF_FFFF);

        // Limit lowered below a held counter
        settle();
        write_reg(REG_DEBOUNCE_LIMIT, 32'd4);
        for (k_main = 0; k_main < 5; k_main++) begin
            push_word(FUNC_SAMPLE, 5'd2, 1'b1, 32'd1000 + 32'(k_main));
        end
        settle();
        write_reg(REG_DEBOUNCE_LIMIT, 32'd1);
        push_word(FUNC_SAMPLE, 5'd2, 1'b1, 32'd1010);
        push_word(FUNC_SAMPLE, 5'd2, 1'b0, 32'd1020);
        // Limit of zero rises on the first high sample
        settle();
        write_reg(REG_DEBOUNCE_LIMIT, 32'd0);
        push_word(FUNC_SAMPLE, 5'd3, 1'b1, 32'd2000);

        set_config(8'd3, 32'd1000, $urandom());
        fill_random(150);

        set_config(8'd0, 32'd0, 32'hFFFF_FFFF);
        fill_random(100);

        set_config(8'hFF, 32'hFFFF_FFFF, 32'd0);
        fill_random(40);
        // One full-limit run on a pin that is low now
        settle();
        long_pin = 7;
        for (k_main = 0; k_main < PIN_COUNT; k_main++) begin
            if (!level_st[k_main]) begin
                long_pin = k_main;
            end
        end
        for (k_main = 0; k_main < 257; k_main++) begin
            clock_ms += $urandom_range(0, 5);
            push_word(FUNC_SAMPLE, long_pin[PIN_W-1:0], 1'b1, clock_ms);
        end
        fill_random(20);

        set_config(8'd1, 32'd50, $urandom());
        fill_random(120);

        set_config(8'($urandom_range(2, 7)), $urandom_range(20, 400), $urandom());
        fill_random(80);

        settle();
        repeat (20) @(negedge aclk);
        if (expected_reports.size() != 0) begin
            report_mismatch("results still expected at the end");
        end
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/dpwm_pkg.sv
src/dpwm_front.sv
src/dpwm_queue.sv
src/dpwm_back.sv
src/debounce_pulse_width_monitor_unit.sv
tb/tb_debounce_pulse_width_monitor_unit.sv
